>>> hdl/dftps_pkg.sv
// Shared types and constants for the direct Fourier power-sum block.
// No dependencies; used by dftps_front, dftps_back and the top level.
`default_nettype none
package dftps_pkg;

    // Request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [7:0] CFG_NUM_POINTS = 8'd0;
    localparam logic [7:0] CFG_NORM_RECIP = 8'd1;

    localparam logic [31:0] NORM_RECIP_RESET = 32'd206807;
    localparam logic [33:0] CORDIC_GAIN_Q30  = 34'd652032874;
    localparam logic [63:0] MAG_CAP          = 64'h7FFF_FFFF;
    localparam logic [35:0] POWER_MAX        = 36'hF_FFFF_FFFF;

    // One queued request as taken from the command port
    typedef struct packed {
        logic        req_type;
        logic [11:0] point_index;
        logic [19:0] coord_x;
        logic [19:0] coord_y;
        logic [19:0] coord_z;
        logic        point_accepted;
        logic [23:0] wave_x;
        logic [23:0] wave_y;
        logic [23:0] wave_z;
    } cmd_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

    // Arctangent of 2^-i in units of 2^-32 turn, rounded
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] r;
        case (i)
            0:       r = 32'd536870912;
            1:       r = 32'd316933406;
            2:       r = 32'd167458907;
            3:       r = 32'd85004756;
            4:       r = 32'd42667331;
            5:       r = 32'd21354465;
            6:       r = 32'd10679843;
            7:       r = 32'd5340245;
            8:       r = 32'd2670163;
            9:       r = 32'd1335087;
            10:      r = 32'd667544;
            11:      r = 32'd333772;
            12:      r = 32'd166886;
            13:      r = 32'd83443;
            14:      r = 32'd41722;
            15:      r = 32'd20861;
            16:      r = 32'd10430;
            17:      r = 32'd5215;
            18:      r = 32'd2608;
            19:      r = 32'd1304;
            20:      r = 32'd652;
            21:      r = 32'd326;
            22:      r = 32'd163;
            23:      r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/direct_dft_power_sum.sv
// Direct Fourier power sum: a query walks the first min(num_points, MAX_POINTS)
// stored points, one per cycle, through the store read, phase multiply and CORDIC
// pipeline, then a scale, round, square and sum tail. One item is worked on at a time.
// Reset clears control, counters, configuration and result registers; the
// datapath registers, queue slots and point store are not cleared.
// Results appear on done for one cycle; the receiver cannot stall.
`default_nettype none
module direct_dft_power_sum #(
    parameter int MAX_POINTS = 4096,
    parameter int COORD_BITS = 20,
    parameter int TRIG_BITS  = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        req_type,
    input  wire logic [11:0] point_index,
    input  wire logic [19:0] coord_x,
    input  wire logic [19:0] coord_y,
    input  wire logic [19:0] coord_z,
    input  wire logic        point_accepted,
    input  wire logic [23:0] wave_x,
    input  wire logic [23:0] wave_y,
    input  wire logic [23:0] wave_z,
    output logic             done,
    output logic [35:0]      power,
    output logic [12:0]      accepted_used,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    dftps_pkg::cmd_t  in_cmd;
    dftps_pkg::head_t head;
    logic             pop;
    logic [12:0]      num_points_reg;
    logic [31:0]      norm_recip_reg;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= 13'd0;
            norm_recip_reg <= dftps_pkg::NORM_RECIP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == dftps_pkg::CFG_NUM_POINTS)
            begin
                num_points_reg <= cfg_data[12:0];
            end
            else if (cfg_index == dftps_pkg::CFG_NORM_RECIP)
            begin
                norm_recip_reg <= cfg_data;
            end
        end
    end

    assign in_cmd = '{req_type: req_type, point_index: point_index,
                      coord_x: coord_x, coord_y: coord_y, coord_z: coord_z,
                      point_accepted: point_accepted, wave_x: wave_x,
                      wave_y: wave_y, wave_z: wave_z};

    dftps_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (start && !busy),
        .push_cmd (in_cmd),
        .pop      (pop),
        .head     (head),
        .full     (busy)
    );

    dftps_back #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .TRIG_BITS  (TRIG_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .num_points    (num_points_reg),
        .norm_recip    (norm_recip_reg),
        .done          (done),
        .power         (power),
        .accepted_used (accepted_used)
    );

endmodule
`default_nettype wire

>>> hdl/dftps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dftps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> hdl/dftps_front.sv
// Front end: takes requests from the command port into a two-entry queue.
// Depends on dftps_pkg.
`default_nettype none
module dftps_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire dftps_pkg::cmd_t push_cmd,
    input  wire logic            pop,
    output dftps_pkg::head_t     head,
    output logic                 full
);

    dftps_pkg::cmd_t slot_reg [0:1];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    // Store payload at the write pointer
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = slot_reg[rd_ptr_reg];
    assign full       = (count_reg == 2'd2);

endmodule
`default_nettype wire

>>> hdl/dftps_back.sv
// Back end: point store, pipelined phase and CORDIC walk, accumulate, scale.
// Depends on dftps_pkg and dftps_ram.
`default_nettype none
module dftps_back #(
    parameter int MAX_POINTS = 4096,
    parameter int COORD_BITS = 20,
    parameter int TRIG_BITS  = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dftps_pkg::head_t head,
    output logic                  pop,
    input  wire logic [12:0]      num_points,
    input  wire logic [31:0]      norm_recip,
    output logic                  done,
    output logic [35:0]           power,
    output logic [12:0]           accepted_used
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int MW  = 24 + COORD_BITS;
    localparam int RW  = 3 * COORD_BITS + 1;
    localparam int SH  = TRIG_BITS + 16;
    localparam int OSH = 30 - TRIG_BITS;

    typedef enum logic [2:0] {
        B_IDLE, B_WALK, B_SCALE, B_ROUND, B_SQUARE, B_SUM
    } bstate_t;

    bstate_t state_reg;

    // Store write
    logic [16:0]   idx_ext;
    logic          ram_we;
    logic [RW-1:0] ram_wdata, ram_rdata;
    logic [AW-1:0] ram_raddr;
    logic [COORD_BITS+19:0] wx_ext, wy_ext, wz_ext;

    assign idx_ext = {5'd0, head.cmd.point_index};
    assign wx_ext  = {{COORD_BITS{1'b0}}, head.cmd.coord_x};
    assign wy_ext  = {{COORD_BITS{1'b0}}, head.cmd.coord_y};
    assign wz_ext  = {{COORD_BITS{1'b0}}, head.cmd.coord_z};
    assign pop     = (state_reg == B_IDLE) && head.valid;
    assign ram_we  = pop && (head.cmd.req_type == dftps_pkg::REQ_LOAD)
                     && (32'(idx_ext) < 32'(MAX_POINTS));
    assign ram_wdata = {wx_ext[COORD_BITS-1:0], wy_ext[COORD_BITS-1:0],
                        wz_ext[COORD_BITS-1:0], head.cmd.point_accepted};

    dftps_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_ext[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Walk control
    logic [CW-1:0] j_reg, n_reg;
    logic          issued_reg;
    logic          issuing, issue_last;
    logic signed [23:0] kx_reg, ky_reg, kz_reg;
    logic [31:0]   nr_reg;

    assign issuing    = (state_reg == B_WALK) && !issued_reg;
    assign issue_last = (n_reg == '0) || ((j_reg + CW'(1)) == n_reg);
    assign ram_raddr  = j_reg[AW-1:0];

    // Read stage
    logic iss_live_reg, iss_last_reg;
    // Multiply stage
    logic        m_v_reg, m_last_reg;
    logic [31:0] px_reg, py_reg, pz_reg;
    logic signed [MW-1:0] px_full, py_full, pz_full;
    logic signed [COORD_BITS-1:0] rx, ry, rz;

    assign rx = ram_rdata[RW-1 -: COORD_BITS];
    assign ry = ram_rdata[RW-1-COORD_BITS -: COORD_BITS];
    assign rz = ram_rdata[COORD_BITS:1];
    assign px_full = MW'(kx_reg) * MW'(rx);
    assign py_full = MW'(ky_reg) * MW'(ry);
    assign pz_full = MW'(kz_reg) * MW'(rz);

    // Phase and fold stage feeds CORDIC stage 0
    logic        c_v  [0:TRIG_BITS];
    logic        c_l  [0:TRIG_BITS];
    logic        c_f  [0:TRIG_BITS];
    logic signed [33:0] c_x [0:TRIG_BITS];
    logic signed [33:0] c_y [0:TRIG_BITS];
    logic signed [33:0] c_z [0:TRIG_BITS];
    logic [31:0]        phase;
    logic signed [33:0] zs, zf;
    logic               fold;

    assign phase = px_reg + py_reg + pz_reg;
    assign zs    = {{2{phase[31]}}, phase};
    assign fold  = (zs > 34'sd1073741824) || (zs < -34'sd1073741824);
    assign zf    = !fold ? zs : (zs > 34'sd0 ? zs - 34'sd2147483648
                                             : zs + 34'sd2147483648);

    // Pipeline control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_live_reg <= 1'b0;
            iss_last_reg <= 1'b0;
            m_v_reg      <= 1'b0;
            m_last_reg   <= 1'b0;
            c_v[0]       <= 1'b0;
            c_l[0]       <= 1'b0;
        end
        else
        begin
            iss_live_reg <= issuing && (n_reg != '0);
            iss_last_reg <= issuing && issue_last;
            m_v_reg      <= iss_live_reg && ram_rdata[0];
            m_last_reg   <= iss_last_reg;
            c_v[0]       <= m_v_reg;
            c_l[0]       <= m_last_reg;
        end
    end

    // Products and folded angle
    always_ff @(posedge clk)
    begin
        px_reg <= px_full[31:0];
        py_reg <= py_full[31:0];
        pz_reg <= pz_full[31:0];
        c_x[0] <= $signed(dftps_pkg::CORDIC_GAIN_Q30);
        c_y[0] <= 34'sd0;
        c_z[0] <= zf;
        c_f[0] <= fold;
    end

    // CORDIC rotation stages, one per step
    genvar g;
    generate
        for (g = 0; g < TRIG_BITS; g++)
        begin : g_cordic
            localparam logic signed [33:0] ATAN = $signed({2'b00, dftps_pkg::atan_turn(g)});
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    c_v[g+1] <= 1'b0;
                    c_l[g+1] <= 1'b0;
                end
                else
                begin
                    c_v[g+1] <= c_v[g];
                    c_l[g+1] <= c_l[g];
                end
            end
            always_ff @(posedge clk)
            begin
                c_f[g+1] <= c_f[g];
                if (!c_z[g][33])
                begin
                    c_x[g+1] <= c_x[g] - (c_y[g] >>> g);
                    c_y[g+1] <= c_y[g] + (c_x[g] >>> g);
                    c_z[g+1] <= c_z[g] - ATAN;
                end
                else
                begin
                    c_x[g+1] <= c_x[g] + (c_y[g] >>> g);
                    c_y[g+1] <= c_y[g] - (c_x[g] >>> g);
                    c_z[g+1] <= c_z[g] + ATAN;
                end
            end
        end
    endgenerate

    // Final sign and scale to TRIG_BITS fraction bits
    logic signed [33:0] fx, fy, cs, sn;
    assign fx = c_f[TRIG_BITS] ? -c_x[TRIG_BITS] : c_x[TRIG_BITS];
    assign fy = c_f[TRIG_BITS] ? -c_y[TRIG_BITS] : c_y[TRIG_BITS];
    assign cs = fx >>> OSH;
    assign sn = fy >>> OSH;

    // Scaling datapath
    logic [31:0] racc_reg, iacc_reg, rabs, iabs;
    logic [63:0] rprod_reg, iprod_reg, rrnd, irnd;
    logic [30:0] rmag_reg, imag_reg;
    logic [61:0] rsq_reg, isq_reg;
    logic [62:0] psum;
    logic [12:0] used_reg;

    assign rabs = racc_reg[31] ? 32'(-racc_reg) : racc_reg;
    assign iabs = iacc_reg[31] ? 32'(-iacc_reg) : iacc_reg;
    assign rrnd = (rprod_reg + (64'd1 << (SH - 1))) >> SH;
    assign irnd = (iprod_reg + (64'd1 << (SH - 1))) >> SH;
    assign psum = {1'b0, rsq_reg} + {1'b0, isq_reg};

    // Sequencer, accumulators and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            j_reg         <= '0;
            n_reg         <= '0;
            issued_reg    <= 1'b0;
            racc_reg      <= 32'd0;
            iacc_reg      <= 32'd0;
            used_reg      <= 13'd0;
            done          <= 1'b0;
            power         <= 36'd0;
            accepted_used <= 13'd0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (pop && (head.cmd.req_type == dftps_pkg::REQ_QUERY))
                    begin
                        j_reg      <= '0;
                        issued_reg <= 1'b0;
                        racc_reg   <= 32'd0;
                        iacc_reg   <= 32'd0;
                        used_reg   <= 13'd0;
                        if (32'(num_points) > 32'(MAX_POINTS))
                        begin
                            n_reg <= CW'(MAX_POINTS);
                        end
                        else
                        begin
                            n_reg <= CW'(num_points);
                        end
                        state_reg <= B_WALK;
                    end
                end
                B_WALK:
                begin
                    if (issuing)
                    begin
                        j_reg <= j_reg + CW'(1);
                        if (issue_last)
                        begin
                            issued_reg <= 1'b1;
                        end
                    end
                    if (c_v[TRIG_BITS])
                    begin
                        racc_reg <= racc_reg + cs[31:0];
                        iacc_reg <= iacc_reg + sn[31:0];
                        used_reg <= used_reg + 13'd1;
                    end
                    if (c_l[TRIG_BITS])
                    begin
                        state_reg <= B_SCALE;
                    end
                end
                B_SCALE:
                begin
                    state_reg <= B_ROUND;
                end
                B_ROUND:
                begin
                    state_reg <= B_SQUARE;
                end
                B_SQUARE:
                begin
                    state_reg <= B_SUM;
                end
                B_SUM:
                begin
                    done          <= 1'b1;
                    accepted_used <= used_reg;
                    power         <= (psum > 63'(dftps_pkg::POWER_MAX))
                                     ? dftps_pkg::POWER_MAX : psum[35:0];
                    state_reg     <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // Wave vector, normalizer and scaling registers
    always_ff @(posedge clk)
    begin
        if (pop && (head.cmd.req_type == dftps_pkg::REQ_QUERY))
        begin
            kx_reg <= $signed(head.cmd.wave_x);
            ky_reg <= $signed(head.cmd.wave_y);
            kz_reg <= $signed(head.cmd.wave_z);
            nr_reg <= norm_recip;
        end
        rprod_reg <= 64'(rabs) * 64'(nr_reg);
        iprod_reg <= 64'(iabs) * 64'(nr_reg);
        rmag_reg  <= (rrnd > dftps_pkg::MAG_CAP) ? 31'h7FFF_FFFF : rrnd[30:0];
        imag_reg  <= (irnd > dftps_pkg::MAG_CAP) ? 31'h7FFF_FFFF : irnd[30:0];
        rsq_reg   <= 62'(rmag_reg) * 62'(rmag_reg);
        isq_reg   <= 62'(imag_reg) * 62'(imag_reg);
    end

endmodule
`default_nettype wire
